// ----- rtl/linear_resampler_assert.svh -----
// Assertion macros used by the checker file of the resampler.
`ifndef LINEAR_RESAMPLER_ASSERT_SVH
`define LINEAR_RESAMPLER_ASSERT_SVH

// Clocked check that is switched off while reset is held.
`define LR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("linear_resampler assertion failed");

// Clocked check that also runs during reset.
`define LR_ASSERT_NORST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("linear_resampler reset assertion failed");

`endif

// ----- rtl/lr_pkg.sv -----
`timescale 1ns / 1ps

package lr_pkg;

    localparam int RATE_W = 19;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_UPSAMPLE_DEF = 16;

    localparam logic [RATE_W-1:0] OUTPUT_RATE_RESET = RATE_W'(48000);

    // Register index, taken from paddr[2].
    localparam logic REG_OUTPUT_RATE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_SELECT,
        ST_IV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_start;
        logic open_buf;
        logic iv_first;
        logic iv_hold;
        logic mul;
        logic emit;
        logic iv_end;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic start_buf;
        logic need_div;
        logic div_done;
        logic have_prev;
        logic last;
        logic in_iv;
        logic more_iv;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/linear_resampler.sv -----
// Flow: an accepted request passes the check, select, interval and output states
// before a result reaches the output register; the first sample of a buffer also
// waits in the divide state for the step divider when a division is needed.
// A new sample is taken only once the last one is finished; output stalls add more.
// Reset: synchronous, active low; clears the sequencer, position, history and
// output valid, and sets output_rate to 48000 with a step of one.
`timescale 1ns / 1ps

module linear_resampler
    import lr_pkg::*;
#(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int MAX_UPSAMPLE = MAX_UPSAMPLE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_in_sample,
    input  logic [RATE_W-1:0]             i_source_rate,
    input  logic                          i_buffer_last,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_out_sample,
    output logic                          o_run_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_AW-1:0]             paddr,
    input  logic [APB_DW-1:0]             pwdata,
    output logic [APB_DW-1:0]             prdata,
    output logic                          pready
);

    logic [RATE_W-1:0] r_output_rate;
    t_cmd              w_cmd;
    t_sts              w_sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_rate <= OUTPUT_RATE_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == REG_OUTPUT_RATE)) begin
            r_output_rate <= pwdata[RATE_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_OUTPUT_RATE) begin
            prdata = {{(APB_DW-RATE_W){1'b0}}, r_output_rate};
        end else begin
            prdata = '0;
        end
    end

    lr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lr_dp #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .FRAC_BITS    (FRAC_BITS),
        .MAX_UPSAMPLE (MAX_UPSAMPLE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_in_sample   (i_in_sample),
        .i_source_rate (i_source_rate),
        .i_buffer_last (i_buffer_last),
        .i_output_rate (r_output_rate),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_out_sample  (o_out_sample),
        .o_run_last    (o_run_last)
    );

endmodule

// ----- rtl/lr_div.sv -----
`timescale 1ns / 1ps

module lr_div
    import lr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [RATE_W-1:0]             i_num,
    input  logic [RATE_W-1:0]             i_den,
    output logic                          o_done,
    output logic [RATE_W+FRAC_BITS-1:0]   o_quo
);

    localparam int QW = RATE_W + FRAC_BITS;
    localparam int CW = $clog2(QW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [RATE_W-1:0] r_rem;
    logic [QW-1:0] r_quo;

    logic [RATE_W:0] w_sh;
    logic [RATE_W:0] w_sub;
    logic            w_ge;

    // One quotient bit per cycle, restoring form.
    assign w_sh  = {r_rem, r_quo[QW-1]};
    assign w_ge  = (w_sh >= {1'b0, i_den});
    assign w_sub = w_sh - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= {i_num, {FRAC_BITS{1'b0}}};
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[RATE_W-1:0] : w_sh[RATE_W-1:0];
            r_quo <= {r_quo[QW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- rtl/lr_ctrl.sv -----
`timescale 1ns / 1ps

module lr_ctrl
    import lr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.start_buf && i_sts.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    o_cmd.open_buf = i_sts.start_buf;
                    n_state        = ST_SELECT;
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.open_buf = 1'b1;
                    n_state        = ST_SELECT;
                end
            end
            ST_SELECT: begin
                // A first sample without the last flag only primes the history.
                if (i_sts.have_prev) begin
                    o_cmd.iv_first = 1'b1;
                    n_state        = ST_IV;
                end else if (i_sts.last) begin
                    o_cmd.iv_hold = 1'b1;
                    n_state       = ST_IV;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_IV: begin
                if (i_sts.in_iv) begin
                    o_cmd.mul = 1'b1;
                    n_state   = ST_OUT;
                end else begin
                    o_cmd.iv_end = 1'b1;
                    if (!i_sts.more_iv) begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IV;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/lr_dp.sv -----
`timescale 1ns / 1ps

module lr_dp
    import lr_pkg::*;
#(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int MAX_UPSAMPLE = MAX_UPSAMPLE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    output t_sts                          o_sts,
    input  logic signed [SAMPLE_BITS-1:0] i_in_sample,
    input  logic [RATE_W-1:0]             i_source_rate,
    input  logic                          i_buffer_last,
    input  logic [RATE_W-1:0]             i_output_rate,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [SAMPLE_BITS-1:0] o_out_sample,
    output logic                          o_run_last
);

    localparam int PH_W = 8 + FRAC_BITS;
    localparam int QW   = RATE_W + FRAC_BITS;
    localparam int PW   = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int DW   = PW - FRAC_BITS;
    localparam logic [PH_W-1:0] ONE      = PH_W'(1) << FRAC_BITS;
    localparam logic [PH_W-1:0] STEP_MAX = '1;
    localparam logic [PH_W-1:0] STEP_MIN =
        PH_W'((2 ** FRAC_BITS + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE);
    localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    logic signed [SAMPLE_BITS-1:0] r_cur;
    logic signed [SAMPLE_BITS-1:0] r_prev;
    logic [RATE_W-1:0]             r_src;
    logic                          r_last;
    logic                          r_in_buffer;
    logic                          r_have_prev;
    logic                          r_second;
    logic [PH_W:0]                 r_phase;
    logic [PH_W-1:0]               r_step;
    logic signed [PW-1:0]          r_prod;
    logic signed [SAMPLE_BITS-1:0] r_base;
    logic                          r_olast;
    logic                          r_ovalid;
    logic signed [SAMPLE_BITS-1:0] r_osample;
    logic                          r_orun_last;

    logic                          w_div_done;
    logic [QW-1:0]                 w_quo;
    logic [PH_W-1:0]               w_quo_sat;
    logic [PH_W-1:0]               w_step_new;
    logic [PH_W:0]                 w_next;
    logic signed [SAMPLE_BITS-1:0] w_a;
    logic signed [SAMPLE_BITS:0]   w_diff;
    logic signed [FRAC_BITS:0]     w_frac;
    logic signed [PW-1:0]          w_prod;
    logic signed [PW-1:0]          w_round;
    logic signed [DW-1:0]          w_delta;
    logic signed [DW-1:0]          w_sum;
    logic                          w_more_iv;
    logic                          w_res_last;

    lr_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_src),
        .i_den   (i_output_rate),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Step of a new buffer, saturated to the supported range.
    always_comb begin
        if (|w_quo[QW-1:PH_W]) begin
            w_quo_sat = STEP_MAX;
        end else begin
            w_quo_sat = w_quo[PH_W-1:0];
        end
        if (r_src == '0) begin
            w_step_new = ONE;
        end else if (i_output_rate == '0) begin
            w_step_new = STEP_MAX;
        end else if (w_quo_sat < STEP_MIN) begin
            w_step_new = STEP_MIN;
        end else begin
            w_step_new = w_quo_sat;
        end
    end

    assign w_next    = r_phase + {1'b0, r_step};
    assign w_more_iv = !r_second && r_last;
    // The result closes the item unless a later read position still lands in
    // this interval or in the flat interval that follows the final sample.
    assign w_res_last = (w_next[PH_W:FRAC_BITS] != '0) &&
                        (!w_more_iv || (w_next[PH_W:FRAC_BITS+1] != '0));

    assign w_a    = r_second ? r_cur : r_prev;
    assign w_diff = {r_cur[SAMPLE_BITS-1], r_cur} - {w_a[SAMPLE_BITS-1], w_a};
    assign w_frac = {1'b0, r_phase[FRAC_BITS-1:0]};
    assign w_prod = w_diff * w_frac;

    // Floor of the rounded product is an arithmetic shift.
    assign w_round = r_prod + HALF;
    assign w_delta = w_round[PW-1:FRAC_BITS];
    assign w_sum   = {{(DW-SAMPLE_BITS){r_base[SAMPLE_BITS-1]}}, r_base} + w_delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_buffer <= 1'b0;
            r_have_prev <= 1'b0;
            r_second    <= 1'b0;
            r_phase     <= '0;
            r_step      <= ONE;
            r_prev      <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cmd.open_buf) begin
                r_step      <= w_step_new;
                r_in_buffer <= 1'b1;
                r_have_prev <= 1'b0;
            end
            if (i_cmd.iv_first) begin
                r_second <= 1'b0;
            end else if (i_cmd.iv_hold || (i_cmd.iv_end && w_more_iv)) begin
                r_second <= 1'b1;
            end

            if (i_cmd.open_buf || (i_cmd.finish && r_last)) begin
                r_phase <= '0;
            end else if (i_cmd.iv_end) begin
                r_phase <= r_phase - {1'b0, ONE};
            end else if (i_cmd.emit) begin
                r_phase <= w_next;
            end

            if (i_cmd.finish) begin
                r_prev      <= r_cur;
                r_have_prev <= !r_last;
                if (r_last) begin
                    r_in_buffer <= 1'b0;
                end
            end

            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur  <= i_in_sample;
            r_src  <= i_source_rate;
            r_last <= i_buffer_last;
        end
        if (i_cmd.mul) begin
            r_prod  <= w_prod;
            r_base  <= w_a;
            r_olast <= w_res_last;
        end
        if (i_cmd.emit) begin
            r_osample   <= w_sum[SAMPLE_BITS-1:0];
            r_orun_last <= r_olast;
        end
    end

    always_comb begin
        o_sts.start_buf = !r_in_buffer;
        o_sts.need_div  = (r_src != '0) && (i_output_rate != '0);
        o_sts.div_done  = w_div_done;
        o_sts.have_prev = r_have_prev;
        o_sts.last      = r_last;
        o_sts.in_iv     = (r_phase[PH_W:FRAC_BITS] == '0);
        o_sts.more_iv   = w_more_iv;
        o_sts.out_free  = !r_ovalid || i_out_ready;
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_sample = r_osample;
    assign o_run_last   = r_orun_last;

endmodule

// ----- rtl/lr_checker.sv -----
`timescale 1ns / 1ps
`include "linear_resampler_assert.svh"

module lr_checker
    import lr_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [SAMPLE_BITS-1:0] o_out_sample,
    input logic                          o_run_last,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [APB_AW-1:0]             paddr,
    input logic [APB_DW-1:0]             pwdata,
    input logic [APB_DW-1:0]             prdata,
    input logic                          pready
);

    logic              w_out_stall;
    logic              w_rate_sel;
    logic              w_rate_wr;
    logic [RATE_W-1:0] w_wdata;
    logic [RATE_W-1:0] w_rdata;

    assign w_out_stall = o_out_valid && !i_out_ready;
    assign w_rate_sel  = (paddr[2] == REG_OUTPUT_RATE);
    assign w_rate_wr   = psel && penable && pwrite && pready && w_rate_sel;
    assign w_wdata     = pwdata[RATE_W-1:0];
    assign w_rdata     = prdata[RATE_W-1:0];

    // A sample is worked on alone, so the input closes right after a request.
    `LR_ASSERT(a_in_busy, i_in_valid && o_in_ready |=> !o_in_ready)

    `LR_ASSERT(a_out_hold, w_out_stall |=> o_out_valid && $stable(o_out_sample) && $stable(o_run_last))

    `LR_ASSERT(a_cfg_readback, w_rate_wr |=> !w_rate_sel || (w_rdata == $past(w_wdata)))

    `LR_ASSERT_NORST(a_reset_idle, !i_rst_n |=> !o_out_valid && o_in_ready)

endmodule

bind linear_resampler lr_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_lr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_sample (o_out_sample),
    .o_run_last   (o_run_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import lr_pkg::*;

    localparam int              CLK_PERIOD    = 12;
    localparam int              FRAC_BITS     = FRAC_BITS_DEF;
    localparam int unsigned     ONE_POS       = 1 << FRAC_BITS;
    localparam longint unsigned STEP_CEIL     = (64'd1 << (8 + FRAC_BITS)) - 1;
    localparam longint unsigned STEP_FLOOR    =
        (ONE_POS + MAX_UPSAMPLE_DEF - 1) / MAX_UPSAMPLE_DEF;
    localparam longint          HALF_LSB      = ONE_POS / 2;
    localparam int              SETTLE_CYCLES = 100;
    localparam int              HOLD_CYCLES   = 400;
    localparam int              PHASE_ITEMS   = 21;
    localparam int              CYCLE_LIMIT   = 2000000;

    localparam logic [APB_AW-1:0] RATE_ADDR = {REG_OUTPUT_RATE, 2'b00};

    typedef logic signed [SAMPLE_BITS_DEF-1:0] t_sample;
    typedef logic [RATE_W-1:0] t_rate;

    typedef struct {
        t_sample smp;
        logic    fin;
    } t_out_word;

    typedef enum logic {
        ROW_ITEM,
        ROW_RATE
    } t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_sample   smp;
        t_rate     rate;
        logic      last;
        bit        typed;
        t_sample   typed_smp;
    } t_row;

    localparam t_rate COMMON_RATES[11] = '{
        8000, 11025, 16000, 22050, 32000, 44100, 48000, 88200, 96000, 192000, 384000
    };
    localparam t_rate PHASE_RATES[9] = '{
        48000, 44100, 96000, 0, 1, 384000, 524287, 8000, 22050
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_sample     i_in_sample;
    t_rate       i_source_rate;
    logic        i_buffer_last;
    logic        o_out_valid;
    logic        i_out_ready;
    t_sample     o_out_sample;
    logic        o_run_last;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Predictor state: read position, step, held sample and buffer flags.
    int unsigned read_pos;
    int unsigned step_size;
    t_sample     prev_smp;
    bit          prev_ok;
    bit          buf_open;
    t_rate       rate_setting;

    t_out_word fresh_outputs[$];
    t_out_word expected_outputs[$];
    t_row      rows[$];
    int        fail_count = 0;
    bit        steady = 1'b0;
    bit        hold_req = 1'b0;

    linear_resampler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_sample   (i_in_sample),
        .i_source_rate (i_source_rate),
        .i_buffer_last (i_buffer_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_sample  (o_out_sample),
        .o_run_last    (o_run_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Rounds to nearest with ties upward; the arithmetic shift floors negatives.
    function automatic t_sample blend(input t_sample a, input t_sample b,
                                      input int unsigned frac);
        longint prod;
        prod = (longint'(b) - longint'(a)) * longint'(frac) + HALF_LSB;
        return SAMPLE_BITS_DEF'(longint'(a) + (prod >>> FRAC_BITS));
    endfunction

    function automatic void fill_interval(input t_sample a, input t_sample b);
        while (read_pos < ONE_POS) begin
            fresh_outputs.push_back('{smp: blend(a, b, read_pos), fin: 1'b0});
            read_pos += step_size;
        end
        read_pos -= ONE_POS;
    endfunction

    function automatic void advance_resampler(input t_sample smp, input t_rate rate,
                                              input logic last);
        longint unsigned ratio;
        fresh_outputs.delete();
        if (!buf_open) begin
            if (rate == 0) begin
                ratio = ONE_POS;
            end else if (rate_setting == 0) begin
                ratio = STEP_CEIL;
            end else begin
                ratio = (64'(rate) << FRAC_BITS) / rate_setting;
            end
            if (ratio > STEP_CEIL) begin
                ratio = STEP_CEIL;
            end
            if (ratio < STEP_FLOOR) begin
                ratio = STEP_FLOOR;
            end
            step_size = 32'(ratio);
            read_pos = 0;
            buf_open = 1'b1;
            prev_ok = 1'b0;
        end
        if (prev_ok) begin
            fill_interval(prev_smp, smp);
        end
        prev_smp = smp;
        prev_ok = 1'b1;
        if (last) begin
            // The closing sample is held flat across its own interval.
            fill_interval(smp, smp);
            buf_open = 1'b0;
            prev_ok = 1'b0;
            read_pos = 0;
        end
        if (fresh_outputs.size() > 0) begin
            fresh_outputs[fresh_outputs.size() - 1].fin = 1'b1;
        end
    endfunction

    function automatic t_row item_row(input t_sample smp, input t_rate rate,
                                      input logic last);
        return '{kind: ROW_ITEM, smp: smp, rate: rate, last: last, typed: 1'b0,
                 typed_smp: '0};
    endfunction

    // A lone sample at a step of one comes back unchanged as a single result.
    function automatic t_row flat_row(input t_sample smp, input t_rate rate);
        return '{kind: ROW_ITEM, smp: smp, rate: rate, last: 1'b1, typed: 1'b1,
                 typed_smp: smp};
    endfunction

    function automatic t_row rate_row(input t_rate rate);
        return '{kind: ROW_RATE, smp: '0, rate: rate, last: 1'b0, typed: 1'b0,
                 typed_smp: '0};
    endfunction

    task automatic offer_sample(input t_sample smp, input t_rate rate, input logic last,
                                input bit typed, input t_sample typed_smp);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_in_sample   <= smp;
        i_source_rate <= rate;
        i_buffer_last <= last;
        do @(posedge i_clk); while (!o_in_ready);
        advance_resampler(smp, rate, last);
        if (typed) begin
            fresh_outputs.delete();
            fresh_outputs.push_back('{smp: typed_smp, fin: 1'b1});
        end
        foreach (fresh_outputs[k]) begin
            expected_outputs.push_back(fresh_outputs[k]);
        end
    endtask

    // Must be called in the time step of the last request's acceptance.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup and access cycles; psel stays up so transfers can go back to back.
    task automatic apb_access(input logic wr, input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= RATE_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
    endtask

    task automatic read_rate_back(input t_rate want);
        logic [APB_DW-1:0] rd;
        apb_access(1'b0, '0, rd);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== APB_DW'(want)) begin
            $display("%0t: output_rate readback expected %0d got %0d", $time, want, rd);
            fail_count++;
        end
    endtask

    task automatic write_rate(input t_rate value);
        logic [APB_DW-1:0] rd;
        apb_access(1'b1, APB_DW'(value), rd);
        rate_setting = value;
        read_rate_back(value);
    endtask

    initial begin : sink
        int        stall_left;
        t_out_word want;
        stall_left = 0;
        i_out_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (expected_outputs.size() == 0) begin
                    $display("%0t: unexpected result sample %0d run_last %0b",
                             $time, o_out_sample, o_run_last);
                    fail_count++;
                end else begin
                    want = expected_outputs.pop_front();
                    if (o_out_sample !== want.smp) begin
                        $display("%0t: out_sample expected %0d got %0d",
                                 $time, want.smp, o_out_sample);
                        fail_count++;
                    end
                    if (o_run_last !== want.fin) begin
                        $display("%0t: run_last expected %0b got %0b",
                                 $time, want.fin, o_run_last);
                        fail_count++;
                    end
                end
            end
            if (hold_req) begin
                hold_req <= 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !steady) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("linear_resampler verification failed");
        $finish;
    end

    initial begin : stimulus
        int    sent;
        int    len;
        int    r;
        t_rate first_rate;
        t_rate phase_rate;
        t_sample smp;

        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_in_sample   <= '0;
        i_source_rate <= '0;
        i_buffer_last <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;

        read_pos     = 0;
        step_size    = ONE_POS;
        prev_smp     = '0;
        prev_ok      = 1'b0;
        buf_open     = 1'b0;
        rate_setting = OUTPUT_RATE_RESET;

        // Single-sample buffers at a step of one, full-scale values and zero.
        rows.push_back(flat_row(16'sh7fff, 0));
        rows.push_back(flat_row(-16'sh8000, 0));
        rows.push_back(flat_row(0, 48000));
        // Step of two; source rate on later samples must be ignored.
        rows.push_back(item_row(-16'sh8000, 96000, 1'b0));
        rows.push_back(item_row(16'sh7fff, 0, 1'b0));
        rows.push_back(item_row(-1, 19'h7ffff, 1'b1));
        // Finest step: full swing, then the flat hold.
        rows.push_back(item_row(16'sh7fff, 3000, 1'b0));
        rows.push_back(item_row(-16'sh8000, 0, 1'b1));
        rows.push_back(item_row(12345, 1, 1'b1));
        // Coarse step skips whole intervals, so some requests give nothing.
        rows.push_back(item_row(100, 19'h7ffff, 1'b0));
        rows.push_back(item_row(200, 0, 1'b0));
        rows.push_back(item_row(300, 0, 1'b0));
        rows.push_back(item_row(400, 0, 1'b1));
        rows.push_back(rate_row(0));
        rows.push_back(item_row(-20000, 44100, 1'b0));
        rows.push_back(item_row(20000, 0, 1'b1));
        rows.push_back(rate_row(1));
        rows.push_back(item_row(7, 384000, 1'b1));
        rows.push_back(rate_row(19'h7ffff));
        rows.push_back(item_row(-7, 8000, 1'b1));
        rows.push_back(rate_row(384000));
        rows.push_back(item_row(16'sh5555, 384000, 1'b0));
        rows.push_back(item_row(-16'sh5556, 0, 1'b1));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        read_rate_back(OUTPUT_RATE_RESET);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_RATE) begin
                settle();
                write_rate(rows[i].rate);
            end else begin
                offer_sample(rows[i].smp, rows[i].rate, rows[i].last,
                             rows[i].typed, rows[i].typed_smp);
            end
        end
        settle();

        for (int p = 0; p < 9; p++) begin
            phase_rate = (p == 8) ? t_rate'($urandom_range(2, 383999)) : PHASE_RATES[p];
            write_rate(phase_rate);
            steady = (p == 2);
            // Long receiver stall while the sender keeps pushing requests.
            if (p == 1) begin
                hold_req <= 1'b1;
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 14)
                                                  : $urandom_range(1, 5);
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    first_rate = 0;
                end else if (r < 20) begin
                    first_rate = ($urandom_range(0, 1) == 0) ? t_rate'(1) : 19'h7ffff;
                end else if (r < 70) begin
                    first_rate = COMMON_RATES[$urandom_range(0, 10)];
                end else begin
                    first_rate = t_rate'($urandom_range(1, 384000));
                end
                for (int k = 0; k < len; k++) begin
                    r = $urandom_range(0, 19);
                    smp = (r == 0) ? 16'sh7fff : (r == 1) ? -16'sh8000
                                               : t_sample'($urandom);
                    // Now and then a buffer is left open into the next one.
                    offer_sample(smp, (k == 0) ? first_rate : t_rate'($urandom),
                                 (k == len - 1) && ($urandom_range(0, 9) != 0),
                                 1'b0, '0);
                    sent++;
                end
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("linear_resampler verification clean");
        end else begin
            $display("linear_resampler verification failed");
        end
        $finish;
    end

endmodule

// ----- linear_resampler.f -----
+incdir+rtl
rtl/lr_pkg.sv
rtl/lr_div.sv
rtl/lr_ctrl.sv
rtl/lr_dp.sv
rtl/linear_resampler.sv
rtl/lr_checker.sv
test/testbench.sv
